FILE: hw/rtl/sclr_pkg.sv
// Shared types, codes and constants of the serial command line receiver.
package sclr_pkg;

  localparam int LINE_CAPACITY_DEF = 32;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_ENQ   = 8'h05;
  localparam logic [7:0] CH_BREAK = 8'h15;
  localparam logic [7:0] CH_CAN   = 8'h18;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [1:0] CAN_LIMIT = 2'd3;

  typedef enum logic [2:0] {
    KIND_CHAR     = 3'd0,
    KIND_END      = 3'd1,
    KIND_ACK      = 3'd2,
    KIND_RESET    = 3'd3,
    KIND_BREAK    = 3'd4,
    KIND_OVERFLOW = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    TERM_NONE = 2'd0,
    TERM_CR   = 2'd1,
    TERM_LF   = 2'd2,
    TERM_CRLF = 2'd3
  } term_t;

  typedef enum logic [2:0] {
    OP_ACK         = 3'd0,
    OP_RESET       = 3'd1,
    OP_BREAK       = 3'd2,
    OP_STORE       = 3'd3,
    OP_FLUSH       = 3'd4,
    OP_FLUSH_STORE = 3'd5
  } op_t;

  typedef struct packed {
    op_t        op;
    term_t      term;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] chr;
    logic [5:0] len;
    term_t      term;
    logic       last;
  } res_t;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_CHARS = 1'b1
  } back_state_t;

endpackage

FILE: hw/rtl/sclr_if.sv
// Word channels of the receiver: received bytes in, events out.
interface sclr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sclr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] char_out;
  logic [5:0] line_length;
  logic [1:0] terminator_kind;
  logic       last_of_run;

  modport source (output valid, output event_kind, output char_out, output line_length,
                  output terminator_kind, output last_of_run, input ready);
  modport sink (input valid, input event_kind, input char_out, input line_length,
                input terminator_kind, input last_of_run, output ready);
endinterface

FILE: hw/rtl/serial_command_line_receiver_unit.sv
// Top level of the serial command line receiver.
//
//   channel  dir  word                                                   handshake
//   in_ch    in   rx_byte[7:0]                                           valid/ready
//   out_ch   out  event_kind, char_out, line_length, terminator_kind,   valid/ready
//                 last_of_run
//
// The front end takes one byte per cycle while the 4-entry command queue has room.
// The back end takes a control byte or stored character from the queue whenever the output
// register is free; a line flush dequeues its command, then sends one event per stored
// character and then the line end, paced by the line store read port and the output register.
// Reset (rst_n low, synchronous) empties the queue and clears CAN count, pending CR
// and fill; the line store is not cleared. Output stalls reach the input once the queue fills.
module serial_command_line_receiver_unit #(
  parameter int LINE_CAPACITY = sclr_pkg::LINE_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sclr_in_if.sink     in_ch,
  sclr_out_if.source  out_ch
);

  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  sclr_pkg::cmd_t push_cmd;
  sclr_pkg::cmd_t head_cmd;

  sclr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  sclr_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  sclr_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (head_cmd),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

FILE: hw/rtl/sclr_front.sv
// Front end: classifies received bytes, tracks CAN run and pending CR, issues commands.
module sclr_front (
  input  logic            clk,
  input  logic            rst_n,
  sclr_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            push,
  output sclr_pkg::cmd_t  push_cmd
);

  logic [1:0] restart_count_r, restart_count_nxt;
  logic       cr_pending_r, cr_pending_nxt;
  logic       accept;
  logic       want_push;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign push        = accept && want_push;

  always_comb begin
    restart_count_nxt = restart_count_r;
    cr_pending_nxt    = cr_pending_r;
    want_push         = 1'b0;
    push_cmd.op       = sclr_pkg::OP_STORE;
    push_cmd.term     = sclr_pkg::TERM_NONE;
    push_cmd.data     = in_ch.rx_byte;
    case (in_ch.rx_byte)
      sclr_pkg::CH_ENQ: begin
        restart_count_nxt = '0;
        want_push         = 1'b1;
        push_cmd.op       = sclr_pkg::OP_ACK;
      end
      sclr_pkg::CH_CAN: begin
        if (restart_count_r == sclr_pkg::CAN_LIMIT) begin
          want_push   = 1'b1;
          push_cmd.op = sclr_pkg::OP_RESET;
        end else begin
          restart_count_nxt = restart_count_r + 2'd1;
        end
      end
      sclr_pkg::CH_BREAK: begin
        want_push   = 1'b1;
        push_cmd.op = sclr_pkg::OP_BREAK;
      end
      default: begin
        restart_count_nxt = '0;
        if (cr_pending_r) begin
          want_push = 1'b1;
          if (in_ch.rx_byte == sclr_pkg::CH_LF) begin
            cr_pending_nxt = 1'b0;
            push_cmd.op    = sclr_pkg::OP_FLUSH;
            push_cmd.term  = sclr_pkg::TERM_CRLF;
          end else if (in_ch.rx_byte == sclr_pkg::CH_CR) begin
            push_cmd.op   = sclr_pkg::OP_FLUSH;
            push_cmd.term = sclr_pkg::TERM_CR;
          end else begin
            cr_pending_nxt = 1'b0;
            push_cmd.op    = sclr_pkg::OP_FLUSH_STORE;
            push_cmd.term  = sclr_pkg::TERM_CR;
          end
        end else if (in_ch.rx_byte == sclr_pkg::CH_CR) begin
          cr_pending_nxt = 1'b1;
        end else if (in_ch.rx_byte == sclr_pkg::CH_LF) begin
          want_push     = 1'b1;
          push_cmd.op   = sclr_pkg::OP_FLUSH;
          push_cmd.term = sclr_pkg::TERM_LF;
        end else begin
          want_push   = 1'b1;
          push_cmd.op = sclr_pkg::OP_STORE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_count_r <= '0;
      cr_pending_r    <= 1'b0;
    end else if (accept) begin
      restart_count_r <= restart_count_nxt;
      cr_pending_r    <= cr_pending_nxt;
    end
  end

endmodule

FILE: hw/rtl/sclr_cmd_fifo.sv
// Short command queue between front end and back end.
module sclr_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sclr_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output sclr_pkg::cmd_t  head_cmd,
  output logic            full,
  output logic            empty
);

  sclr_pkg::cmd_t                  slot_r [sclr_pkg::Q_DEPTH];
  logic [sclr_pkg::Q_AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [sclr_pkg::Q_AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [sclr_pkg::Q_CW-1:0]       count_r, count_nxt;
  logic                            do_push, do_pop;

  assign full     = (count_r == sclr_pkg::Q_CW'(sclr_pkg::Q_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? sclr_pkg::Q_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? sclr_pkg::Q_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + sclr_pkg::Q_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - sclr_pkg::Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hw/rtl/sclr_back.sv
// Back end: executes commands, owns the line store and the event output register.
module sclr_back #(
  parameter int LINE_CAPACITY = sclr_pkg::LINE_CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sclr_pkg::cmd_t  head_cmd,
  input  logic            q_empty,
  output logic            pop,
  sclr_out_if.source      out_ch
);

  localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int CW = $clog2(LINE_CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(LINE_CAPACITY);

  sclr_pkg::back_state_t state_r, state_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  sclr_pkg::cmd_t        cur_r, cur_nxt;
  logic                  out_valid_r, out_valid_nxt;
  sclr_pkg::res_t        res_r, res_nxt;
  logic                  load;
  logic                  out_free;
  logic                  line_done;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [7:0]            wdata;
  logic [AW-1:0]         rd_addr;
  logic [7:0]            rd_data_r;
  logic [7:0]            line_mem [LINE_CAPACITY];

  assign out_free  = !out_valid_r || out_ch.ready;
  assign line_done = (idx_r == fill_r);
  assign rd_addr   = idx_nxt[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sclr_pkg::BK_IDLE: begin
        if (!q_empty && out_free &&
            (head_cmd.op == sclr_pkg::OP_FLUSH || head_cmd.op == sclr_pkg::OP_FLUSH_STORE)) begin
          state_nxt = sclr_pkg::BK_CHARS;
        end
      end
      sclr_pkg::BK_CHARS: begin
        if (out_free && line_done) begin
          state_nxt = sclr_pkg::BK_IDLE;
        end
      end
      default: state_nxt = sclr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load     = 1'b0;
    res_nxt  = '0;
    fill_nxt = fill_r;
    idx_nxt  = idx_r;
    cur_nxt  = cur_r;
    we       = 1'b0;
    waddr    = fill_r[AW-1:0];
    wdata    = head_cmd.data;
    case (state_r)
      sclr_pkg::BK_IDLE: begin
        if (!q_empty && out_free) begin
          pop          = 1'b1;
          res_nxt.last = 1'b1;
          case (head_cmd.op)
            sclr_pkg::OP_ACK: begin
              load         = 1'b1;
              res_nxt.kind = sclr_pkg::KIND_ACK;
            end
            sclr_pkg::OP_RESET: begin
              load         = 1'b1;
              res_nxt.kind = sclr_pkg::KIND_RESET;
            end
            sclr_pkg::OP_BREAK: begin
              load         = 1'b1;
              res_nxt.kind = sclr_pkg::KIND_BREAK;
            end
            sclr_pkg::OP_STORE: begin
              if (fill_r == CAP_CNT) begin
                load         = 1'b1;
                res_nxt.kind = sclr_pkg::KIND_OVERFLOW;
                fill_nxt     = '0;
              end else begin
                we       = 1'b1;
                fill_nxt = fill_r + CW'(1);
              end
            end
            sclr_pkg::OP_FLUSH, sclr_pkg::OP_FLUSH_STORE: begin
              cur_nxt = head_cmd;
              idx_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      sclr_pkg::BK_CHARS: begin
        if (out_free) begin
          load = 1'b1;
          if (line_done) begin
            res_nxt.kind = sclr_pkg::KIND_END;
            res_nxt.len  = 6'(fill_r);
            res_nxt.term = cur_r.term;
            res_nxt.last = 1'b1;
            if (cur_r.op == sclr_pkg::OP_FLUSH_STORE) begin
              we       = 1'b1;
              waddr    = '0;
              wdata    = cur_r.data;
              fill_nxt = CW'(1);
            end else begin
              fill_nxt = '0;
            end
          end else begin
            res_nxt.kind = sclr_pkg::KIND_CHAR;
            res_nxt.chr  = rd_data_r;
            idx_nxt      = idx_r + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sclr_pkg::BK_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (load) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      line_mem[waddr] <= wdata;
    end
    rd_data_r <= line_mem[rd_addr];
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.event_kind      = res_r.kind;
  assign out_ch.char_out        = res_r.chr;
  assign out_ch.line_length     = res_r.len;
  assign out_ch.terminator_kind = res_r.term;
  assign out_ch.last_of_run     = res_r.last;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CAP_CNT)
    else $error("line fill beyond capacity");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sclr_pkg::BK_CHARS |-> idx_r <= fill_r)
    else $error("flush index past line fill");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.kind == sclr_pkg::KIND_END |-> res_r.last)
    else $error("line end not marked last");

  a_char_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.kind == sclr_pkg::KIND_CHAR |-> !res_r.last && res_r.len == '0)
    else $error("line char marked last or with length");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sclr_pkg::BK_CHARS && out_free && line_done |=> fill_r <= CW'(1))
    else $error("fill not reset after line end");

endmodule

FILE: sim/tb_serial_command_line_receiver_unit.sv
// Testbench for the serial command line receiver: directed bytes, random traffic, event checks.
`timescale 1ns / 1ps

module tb_serial_command_line_receiver_unit;
  import sclr_pkg::*;

  localparam int LINE_CAP     = LINE_CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 370;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [7:0] rx;
    int         reps;
    bit         typed;
    res_t       want;
  } row_t;

  logic clk;
  logic rst_n;

  sclr_in_if  in_ch ();
  sclr_out_if out_ch ();

  serial_command_line_receiver_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // receiver state as predicted
  logic [1:0] can_run;
  logic [7:0] line_buf [LINE_CAP];
  int         line_fill;
  bit         cr_held;

  res_t byte_events [$];
  res_t events_due [$];
  row_t dir_rows [$];

  bit calm;
  int mismatches;
  int items_sent;
  int events_seen;
  int lines_seen;
  int overflows_seen;
  int resets_seen;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string fld, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] mismatch on %s at event %0d: got %0d, expected %0d",
               $time, fld, events_seen, got, want);
  endtask

  task automatic add_event(input kind_t k, input logic [7:0] c, input logic [5:0] l,
                           input term_t t);
    res_t e;
    e.kind = k;
    e.chr  = c;
    e.len  = l;
    e.term = t;
    e.last = 1'b0;
    byte_events.push_back(e);
  endtask

  task automatic flush_line(input term_t t);
    for (int i = 0; i < line_fill; i++)
      add_event(KIND_CHAR, line_buf[i], 6'd0, TERM_NONE);
    add_event(KIND_END, 8'h00, 6'(line_fill), t);
    line_fill = 0;
  endtask

  // events one received byte gives, updating the predicted state
  task automatic decode_rx_byte(input logic [7:0] b);
    bit eol_done;
    res_t tail;
    byte_events.delete();
    eol_done = 1'b0;
    if (b == CH_ENQ) begin
      can_run = 2'd0;
      add_event(KIND_ACK, 8'h00, 6'd0, TERM_NONE);
    end else if (b == CH_CAN) begin
      if (can_run == CAN_LIMIT) add_event(KIND_RESET, 8'h00, 6'd0, TERM_NONE);
      else can_run = can_run + 2'd1;
    end else if (b == CH_BREAK) begin
      add_event(KIND_BREAK, 8'h00, 6'd0, TERM_NONE);
    end else begin
      can_run = 2'd0;
      if (cr_held) begin
        cr_held = 1'b0;
        if (b == CH_LF) begin
          flush_line(TERM_CRLF);
          eol_done = 1'b1;
        end else begin
          flush_line(TERM_CR);
        end
      end
      if (!eol_done) begin
        if (b == CH_CR) begin
          cr_held = 1'b1;
        end else if (b == CH_LF) begin
          flush_line(TERM_LF);
        end else if (line_fill >= LINE_CAP) begin
          line_fill = 0;
          add_event(KIND_OVERFLOW, 8'h00, 6'd0, TERM_NONE);
        end else begin
          line_buf[line_fill] = b;
          line_fill++;
        end
      end
    end
    if (byte_events.size() > 0) begin
      tail = byte_events[byte_events.size() - 1];
      tail.last = 1'b1;
      byte_events[byte_events.size() - 1] = tail;
    end
  endtask

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_byte(input logic [7:0] b, input bit typed, input res_t want);
    if (!calm && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < 15);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    decode_rx_byte(b);
    if (typed) begin
      events_due.push_back(want);
    end else begin
      foreach (byte_events[i]) events_due.push_back(byte_events[i]);
    end
  endtask

  task automatic feed(input logic [7:0] b);
    send_byte(b, 1'b0, '0);
  endtask

  task automatic add_row(input logic [7:0] b, input int reps, input bit typed,
                         input kind_t k, input logic [5:0] l, input term_t t);
    row_t r;
    r.rx        = b;
    r.reps      = reps;
    r.typed     = typed;
    r.want.kind = k;
    r.want.chr  = 8'h00;
    r.want.len  = l;
    r.want.term = t;
    r.want.last = 1'b1;
    dir_rows.push_back(r);
  endtask

  function automatic logic [7:0] line_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CH_ENQ || c == CH_CAN || c == CH_BREAK || c == CH_CR || c == CH_LF);
    return c;
  endfunction

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still due", cycles, events_due.size());
      $display("FAIL serial_command_line_receiver_unit");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind = kind_t'(out_ch.event_kind);
      got.chr  = out_ch.char_out;
      got.len  = out_ch.line_length;
      got.term = term_t'(out_ch.terminator_kind);
      got.last = out_ch.last_of_run;
      events_seen++;
      if (got.kind == KIND_END) lines_seen++;
      if (got.kind == KIND_OVERFLOW) overflows_seen++;
      if (got.kind == KIND_RESET) resets_seen++;
      if (events_due.size() == 0) begin
        report_mismatch("unexpected event kind", got.kind, -1);
      end else begin
        want = events_due.pop_front();
        if (got.kind !== want.kind) report_mismatch("event_kind", got.kind, want.kind);
        if (got.chr !== want.chr) report_mismatch("char_out", got.chr, want.chr);
        if (got.len !== want.len) report_mismatch("line_length", got.len, want.len);
        if (got.term !== want.term)
          report_mismatch("terminator_kind", got.term, want.term);
        if (got.last !== want.last) report_mismatch("last_of_run", got.last, want.last);
      end
    end
  end

  initial begin
    int pick;
    int n;
    int stop_at;
    int calm_from;
    logic [7:0] b;

    mismatches     = 0;
    items_sent     = 0;
    events_seen    = 0;
    lines_seen     = 0;
    overflows_seen = 0;
    resets_seen    = 0;
    calm           = 1'b0;
    can_run        = 2'd0;
    line_fill      = 0;
    cr_held        = 1'b0;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;

    add_row(CH_LF,    1, 1, KIND_END,      6'd0, TERM_LF);
    add_row(CH_ENQ,   1, 1, KIND_ACK,      6'd0, TERM_NONE);
    add_row(CH_BREAK, 1, 1, KIND_BREAK,    6'd0, TERM_NONE);
    add_row(CH_CAN,   3, 0, KIND_CHAR,     6'd0, TERM_NONE);
    add_row(CH_BREAK, 1, 1, KIND_BREAK,    6'd0, TERM_NONE);
    add_row(CH_CAN,   1, 1, KIND_RESET,    6'd0, TERM_NONE);
    add_row(CH_CAN,   1, 1, KIND_RESET,    6'd0, TERM_NONE);
    add_row(8'h00,    1, 0, KIND_CHAR,     6'd0, TERM_NONE);
    add_row(8'hFF,    1, 0, KIND_CHAR,     6'd0, TERM_NONE);
    add_row(CH_CR,    1, 0, KIND_CHAR,     6'd0, TERM_NONE);
    add_row(CH_CAN,   1, 0, KIND_CHAR,     6'd0, TERM_NONE);
    add_row(CH_LF,    1, 0, KIND_CHAR,     6'd0, TERM_NONE);
    add_row(CH_CR,    1, 0, KIND_CHAR,     6'd0, TERM_NONE);
    add_row(CH_CR,    1, 1, KIND_END,      6'd0, TERM_CR);
    add_row(8'h41,    1, 0, KIND_CHAR,     6'd0, TERM_NONE);
    add_row(CH_ENQ,   1, 1, KIND_ACK,      6'd0, TERM_NONE);
    add_row(CH_LF,    1, 0, KIND_CHAR,     6'd0, TERM_NONE);
    add_row(8'h55,   32, 0, KIND_CHAR,     6'd0, TERM_NONE);
    add_row(8'hAA,    1, 1, KIND_OVERFLOW, 6'd0, TERM_NONE);
    add_row(CH_LF,    1, 1, KIND_END,      6'd0, TERM_LF);
    add_row(8'h7E,   32, 0, KIND_CHAR,     6'd0, TERM_NONE);
    add_row(CH_CR,    1, 0, KIND_CHAR,     6'd0, TERM_NONE);
    add_row(8'h20,    1, 0, KIND_CHAR,     6'd0, TERM_NONE);
    add_row(CH_LF,    1, 0, KIND_CHAR,     6'd0, TERM_NONE);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      repeat (dir_rows[i].reps) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);

    // random traffic: mostly framed lines, plus CAN bursts, control bytes and noise
    stop_at   = items_sent + RANDOM_ITEMS;
    calm_from = items_sent + 180;
    while (items_sent < stop_at) begin
      calm = (items_sent >= calm_from && items_sent < calm_from + 100);
      pick = $urandom_range(99);
      if (pick < 60) begin
        n = ($urandom_range(7) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 10);
        repeat (n) begin
          if ($urandom_range(19) == 0) begin
            case ($urandom_range(2))
              0: b = CH_ENQ;
              1: b = CH_CAN;
              default: b = CH_BREAK;
            endcase
          end else begin
            b = line_char();
          end
          feed(b);
        end
        case ($urandom_range(3))
          0: feed(CH_CR);
          1: feed(CH_LF);
          2: begin
            feed(CH_CR);
            feed(CH_LF);
          end
          default: ;
        endcase
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 6)) feed(CH_CAN);
        if ($urandom_range(1) == 0) feed(CH_ENQ);
        else feed(line_char());
      end else if (pick < 88) begin
        feed($urandom_range(1) ? CH_ENQ : CH_BREAK);
      end else begin
        repeat ($urandom_range(1, 6)) feed(8'($urandom_range(255)));
      end
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (events_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d received bytes and %0d events: %0d line ends,", items_sent,
             events_seen, lines_seen);
    $display("%0d overflows, %0d reset requests; %0d mismatches", overflows_seen,
             resets_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS serial_command_line_receiver_unit");
    end else begin
      $display("FAIL serial_command_line_receiver_unit");
    end
    $finish;
  end

endmodule
